[rtl/rrsp_pkg.sv]
// Shared constants and codes for the round-robin slot pool.
package rrsp_pkg;

    localparam int SLOT_COUNT_DEFAULT = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // Valid bits are held 32 to a word of the bitmap memory
    localparam int MAP_WORD_W = 32;
    localparam int MAP_OFF_W  = 5;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_NO_ROOM  = 2'd1;
    localparam logic [1:0] STATUS_NOT_RUN  = 2'd2;

endpackage

[rtl/rrsp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module rrsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/round_robin_slot_pool.sv]
// Top level of the round-robin slot pool: search sequencer over bitmap and data memories.
//
// A pool of SLOT_COUNT slots. A push (func 0) stores a value in the first empty slot at or
// after the write pointer, wrapping round, and moves the write pointer just past it; a pop
// (func 1) takes the value from the first full slot at or after the read pointer, empties
// it and moves the read pointer just past it. A transaction is taken when start is high and
// busy is low; its result appears on the o_ result ports for exactly one cycle with
// o_strobe high, and the receiver must take it then, as it cannot stall the block.
// Status 0 is done, 1 is pool full (push) or pool empty (pop), 2 is not running
// (run enable off). Occupancy lives in a bitmap memory of 32-bit words, W = SLOT_COUNT/32
// rounded up words; the search reads one word a cycle, starting with the pointer's word
// and ending with that word again for the bits below the pointer. The found slot's bitmap
// word is written back in the commit state, with the data for a push; a pop then reads the
// data memory in the pop-out state. A refused transaction replies straight from idle, a full
// or empty pool after the last word read. After reset the bitmap is cleared one word a
// cycle, busy staying high until the sweep is done; run enable may be written throughout.
module round_robin_slot_pool #(
    parameter int SLOT_COUNT = rrsp_pkg::SLOT_COUNT_DEFAULT,
    parameter int DATA_WIDTH = rrsp_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [31:0] i_push_value,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_pop_value,
    output logic [5:0]  o_slot_used
);

    localparam int MW        = rrsp_pkg::MAP_WORD_W;
    localparam int OW        = rrsp_pkg::MAP_OFF_W;
    localparam int WORDS     = (SLOT_COUNT + MW - 1) / MW;
    localparam int WW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SW        = $clog2(SLOT_COUNT);
    localparam int CW        = $clog2(WORDS + 1);
    localparam int LAST_BITS = SLOT_COUNT - (WORDS - 1) * MW;
    // Only the last bitmap word can hold bits past the end of the pool
    localparam logic [MW-1:0] LAST_MASK = {MW{1'b1}} >> (MW - LAST_BITS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_POP_OUT
    } t_state;

    t_state                r_state;
    logic                  r_run;
    logic [SW-1:0]         r_wr_ptr;
    logic [SW-1:0]         r_rd_ptr;
    logic                  r_is_pop;
    logic [DATA_WIDTH-1:0] r_data;
    logic [WW-1:0]         r_word;
    logic [OW-1:0]         r_off;
    logic [CW-1:0]         r_step;
    logic [SW-1:0]         r_slot;
    logic [MW-1:0]         r_new_bits;
    logic                  r_strobe;
    logic [1:0]            r_status;
    logic [31:0]           r_pop_value;
    logic [5:0]            r_slot_used;

    // Memory ports
    logic                  bm_we;
    logic [WW-1:0]         bm_raddr;
    logic [MW-1:0]         bm_wdata;
    logic [MW-1:0]         bm_rdata;
    logic                  dt_we;
    logic [DATA_WIDTH-1:0] dt_rdata;

    // Search logic
    logic [SW-1:0]         w_start_ptr;
    logic [WW-1:0]         w_word_next;
    logic [MW-1:0]         w_match;
    logic [MW-1:0]         w_range;
    logic [MW-1:0]         w_upper;
    logic [MW-1:0]         w_cand;
    logic [MW-1:0]         w_onehot;
    logic [OW-1:0]         w_bit;
    logic                  w_found;
    logic                  w_last_step;
    logic [SW-1:0]         w_slot_next;

    assign w_start_ptr = (i_func == rrsp_pkg::FUNC_POP) ? r_rd_ptr : r_wr_ptr;
    assign w_word_next = (r_word == WW'(WORDS - 1)) ? '0 : r_word + 1'b1;
    assign w_last_step = (r_step == CW'(WORDS));
    assign w_slot_next = (r_slot == SW'(SLOT_COUNT - 1)) ? '0 : r_slot + 1'b1;

    always_comb begin
        w_match = r_is_pop ? bm_rdata : ~bm_rdata;
        w_range = (r_word == WW'(WORDS - 1)) ? LAST_MASK : {MW{1'b1}};
        w_upper = {MW{1'b1}} << r_off;
        // First word read covers bits at and above the pointer; the revisit covers the rest
        if (r_step == '0) begin
            w_cand = w_match & w_range & w_upper;
        end else if (w_last_step) begin
            w_cand = w_match & w_range & ~w_upper;
        end else begin
            w_cand = w_match & w_range;
        end
        w_onehot = w_cand & (~w_cand + 1'b1);
        w_found  = |w_cand;
        w_bit    = '0;
        for (int b = 0; b < MW; b++) begin
            if (w_onehot[b]) begin
                w_bit = w_bit | OW'(b);
            end
        end
    end

    // Bitmap: read the start word on acceptance, then walk forward one word a cycle
    always_comb begin
        bm_raddr = (r_state == S_IDLE) ? WW'(w_start_ptr >> OW) : w_word_next;
        bm_we    = (r_state == S_CLEAR) || (r_state == S_COMMIT);
        bm_wdata = (r_state == S_CLEAR) ? '0 : r_new_bits;
    end

    assign dt_we = (r_state == S_COMMIT) && !r_is_pop;

    rrsp_ram #(
        .WIDTH (MW),
        .DEPTH (WORDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (r_word),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    rrsp_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SLOT_COUNT)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dt_we),
        .i_waddr (r_slot),
        .i_wdata (r_data),
        .i_raddr (r_slot),
        .o_rdata (dt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_run    <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_word   <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_run <= i_cfg_wdata;
            end
            r_strobe <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    // Sweep the bitmap to empty, one word a cycle
                    if (r_word == WW'(WORDS - 1)) begin
                        r_word  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_word <= r_word + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_is_pop <= (i_func == rrsp_pkg::FUNC_POP);
                        r_data   <= DATA_WIDTH'(i_push_value);
                        if (!r_run) begin
                            r_strobe    <= 1'b1;
                            r_status    <= rrsp_pkg::STATUS_NOT_RUN;
                            r_pop_value <= '0;
                            r_slot_used <= '0;
                        end else begin
                            r_word  <= WW'(w_start_ptr >> OW);
                            r_off   <= OW'(w_start_ptr);
                            r_step  <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_found) begin
                        // Hold the word; toggle the chosen bit for write-back
                        r_slot     <= SW'({r_word, w_bit});
                        r_new_bits <= bm_rdata ^ w_onehot;
                        r_state    <= S_COMMIT;
                    end else if (w_last_step) begin
                        r_strobe    <= 1'b1;
                        r_status    <= rrsp_pkg::STATUS_NO_ROOM;
                        r_pop_value <= '0;
                        r_slot_used <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_word <= w_word_next;
                        r_step <= r_step + 1'b1;
                    end
                end
                S_COMMIT: begin
                    if (r_is_pop) begin
                        r_rd_ptr <= w_slot_next;
                        r_state  <= S_POP_OUT;
                    end else begin
                        r_wr_ptr    <= w_slot_next;
                        r_strobe    <= 1'b1;
                        r_status    <= rrsp_pkg::STATUS_DONE;
                        r_pop_value <= '0;
                        r_slot_used <= 6'(r_slot);
                        r_state     <= S_IDLE;
                    end
                end
                S_POP_OUT: begin
                    r_strobe    <= 1'b1;
                    r_status    <= rrsp_pkg::STATUS_DONE;
                    r_pop_value <= 32'(dt_rdata);
                    r_slot_used <= 6'(r_slot);
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_pop_value = r_pop_value;
    assign o_slot_used = r_slot_used;

endmodule

[verif/round_robin_slot_pool_checker.sv]
// Scoreboard for the round-robin slot pool: predicts every transaction and checks each reply.
`timescale 1ns / 100ps
module round_robin_slot_pool_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_func,
    input  logic [31:0] i_push_value,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_strobe,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_pop_value,
    input  logic [5:0]  i_slot_used,
    output int          o_pending,
    output int          o_fail_count
);

    localparam int SLOTS = rrsp_pkg::SLOT_COUNT_DEFAULT;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [5:0]  slot;
    } t_pool_reply;

    logic [31:0]     slot_value [SLOTS];
    bit [SLOTS-1:0]  slot_taken;
    logic [5:0]      push_ptr;
    logic [5:0]      pop_ptr;
    bit              running;
    t_pool_reply     replies_due [$];
    int              mismatches = 0;

    // Apply one push or pop to the pool image and return the reply it must give.
    function automatic t_pool_reply serve_request(input logic func, input logic [31:0] payload);
        t_pool_reply reply;
        logic [5:0]  idx;
        logic [5:0]  from;
        logic        want;
        bit          found;
        reply = '{rrsp_pkg::STATUS_DONE, 32'd0, 6'd0};
        found = 1'b0;
        idx   = '0;
        if (!running) begin
            reply.status = rrsp_pkg::STATUS_NOT_RUN;
            return reply;
        end
        from = (func == rrsp_pkg::FUNC_PUSH) ? push_ptr : pop_ptr;
        want = (func == rrsp_pkg::FUNC_POP);
        for (int k = 0; k < SLOTS && !found; k++) begin
            idx = from + 6'(k);
            if (slot_taken[idx] == want)
                found = 1'b1;
        end
        if (!found) begin
            reply.status = rrsp_pkg::STATUS_NO_ROOM;
            return reply;
        end
        if (func == rrsp_pkg::FUNC_PUSH) begin
            slot_value[idx] = payload;
            slot_taken[idx] = 1'b1;
            push_ptr        = idx + 6'd1;
        end else begin
            reply.value     = slot_value[idx];
            slot_taken[idx] = 1'b0;
            pop_ptr         = idx + 6'd1;
        end
        reply.slot = idx;
        return reply;
    endfunction

    task automatic log_fault(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_pool_reply seen;
        t_pool_reply due;
        if (!i_rst_n) begin
            slot_taken = '0;
            push_ptr   = '0;
            pop_ptr    = '0;
            running    = 1'b0;
            replies_due.delete();
        end else begin
            // Compare before predicting: a reply never belongs to a request taken this edge
            if (i_strobe) begin
                seen = '{i_status, i_pop_value, i_slot_used};
                if (replies_due.size() == 0) begin
                    log_fault($sformatf("unexpected reply status=%0d value=%h slot=%0d",
                                        seen.status, seen.value, seen.slot));
                end else begin
                    due = replies_due.pop_front();
                    if (seen.status !== due.status || seen.value !== due.value ||
                        seen.slot !== due.slot)
                        log_fault({
                            $sformatf("reply mismatch: expected status=%0d value=%h slot=%0d",
                                      due.status, due.value, due.slot),
                            $sformatf(", got status=%0d value=%h slot=%0d",
                                      seen.status, seen.value, seen.slot)});
                end
            end
            // A request taken this edge still sees the old run enable
            if (i_start && !i_busy)
                replies_due.push_back(serve_request(i_func, i_push_value));
            if (i_cfg_we)
                running = i_cfg_wdata;
        end
        o_pending    <= replies_due.size();
        o_fail_count <= mismatches;
    end

endmodule

[verif/tb_round_robin_slot_pool.sv]
// Testbench top for the round-robin slot pool: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_round_robin_slot_pool;

    localparam int ITEM_TARGET   = 1750;
    // No random gaps in phases that start within the final stretch of transactions
    localparam int CALM_TAIL     = 250;
    // Watchdog bound on the length of the run, in clock cycles
    localparam int CYCLE_LIMIT   = 400000;
    // Longest search is a pop matching in the last word read
    localparam int SETTLE_CYCLES = 16;

    // Traffic shapes for the random phases
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN,
        MIX_SWEEP,
        MIX_HALTED,
        MIX_LEAN
    } t_mix;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic        busy;
    logic        i_func       = rrsp_pkg::FUNC_PUSH;
    logic [31:0] i_push_value = '0;
    logic        i_cfg_we     = 1'b0;
    logic        i_cfg_wdata  = 1'b0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [31:0] o_pop_value;
    logic [5:0]  o_slot_used;

    int pending;
    int fail_count;
    int cycles      = 0;
    int items_sent  = 0;
    bit allow_gaps  = 1'b1;

    round_robin_slot_pool i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_push_value (i_push_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_pop_value  (o_pop_value),
        .o_slot_used  (o_slot_used)
    );

    round_robin_slot_pool_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_func       (i_func),
        .i_push_value (i_push_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_strobe     (o_strobe),
        .i_status     (o_status),
        .i_pop_value  (o_pop_value),
        .i_slot_used  (o_slot_used),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: abandon a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("round_robin_slot_pool test failed");
            $finish;
        end
    end

    // Mostly full-range random data, with the corner patterns mixed in
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // Present one transaction and hold it until the block takes it. Drop start only
    // when a gap is inserted, so start is never lowered and raised in one step.
    task automatic issue(input logic func, input logic [31:0] payload);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_func       <= func;
        i_push_value <= payload;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // Drain the pipe: stop requesting and wait until every reply has come back
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the run enable only with the block idle
    task automatic write_run_enable(input logic on);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= on;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int   burst;
        int   push_odds;
        int   phase;
        t_mix mix;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: refusals while stopped, then the corner data values
        issue(rrsp_pkg::FUNC_PUSH, 32'h1234_5678);
        issue(rrsp_pkg::FUNC_POP, 32'hFFFF_FFFF);
        write_run_enable(1'b1);
        issue(rrsp_pkg::FUNC_POP, 32'h0);                 // pop on an empty pool
        issue(rrsp_pkg::FUNC_PUSH, 32'h0000_0000);        // a stored zero still marks it full
        issue(rrsp_pkg::FUNC_PUSH, 32'hFFFF_FFFF);
        issue(rrsp_pkg::FUNC_PUSH, 32'h8000_0000);
        issue(rrsp_pkg::FUNC_PUSH, 32'h0000_0001);
        repeat (4) issue(rrsp_pkg::FUNC_POP, $urandom());
        issue(rrsp_pkg::FUNC_POP, 32'h0);                 // empty again after draining
        issue(rrsp_pkg::FUNC_PUSH, 32'hA5A5_A5A5);
        write_run_enable(1'b0);
        issue(rrsp_pkg::FUNC_PUSH, 32'h5A5A_5A5A);        // stopped: no state may change
        issue(rrsp_pkg::FUNC_POP, 32'h0);
        write_run_enable(1'b1);
        issue(rrsp_pkg::FUNC_POP, 32'h0);                 // must still return the held value

        // Random phases, cycling through the traffic shapes
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            mix        = t_mix'(phase % 6);
            allow_gaps = (items_sent < ITEM_TARGET - CALM_TAIL) && (phase % 4 != 3);
            burst      = $urandom_range(60, 140);
            case (mix)
                MIX_FILL:  push_odds = 85;
                MIX_DRAIN: push_odds = 15;
                MIX_LEAN:  push_odds = 60;
                default:   push_odds = 50;
            endcase
            if (mix == MIX_HALTED) begin
                // Stop the job for a short burst, then start it again
                write_run_enable(1'b0);
                repeat (20) issue(logic'($urandom_range(0, 1)), pick_value());
                write_run_enable(1'b1);
            end else if (mix == MIX_SWEEP) begin
                // Overfill then overdrain, so both refusals and every wrap occur
                write_run_enable(1'b1);
                repeat (70) issue(rrsp_pkg::FUNC_PUSH, pick_value());
                repeat (70) issue(rrsp_pkg::FUNC_POP, pick_value());
            end else begin
                write_run_enable(1'b1);
                repeat (burst)
                    issue(($urandom_range(0, 99) < push_odds) ? rrsp_pkg::FUNC_PUSH
                                                              : rrsp_pkg::FUNC_POP,
                          pick_value());
            end
            phase++;
        end

        // Wait out every reply, then allow for any stray strobe
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("round_robin_slot_pool test passed");
        else
            $display("round_robin_slot_pool test failed");
        $finish;
    end

endmodule

[files.f]
rtl/rrsp_pkg.sv
rtl/rrsp_ram.sv
rtl/round_robin_slot_pool.sv
verif/round_robin_slot_pool_checker.sv
verif/tb_round_robin_slot_pool.sv
